>>> rtl/core/vmalu_pkg.sv
package vmalu_pkg;

	localparam int unsigned DataWidth = 32;
	localparam int unsigned OpWidth   = 5;
	localparam int unsigned CntWidth  = 6;

	typedef logic [OpWidth-1:0]   opcode_t;
	typedef logic [DataWidth-1:0] word_t;

	localparam opcode_t OP_JMP  = 5'h01;
	localparam opcode_t OP_JZ   = 5'h02;
	localparam opcode_t OP_JP   = 5'h03;
	localparam opcode_t OP_JN   = 5'h04;
	localparam opcode_t OP_JNZ  = 5'h05;
	localparam opcode_t OP_JNP  = 5'h06;
	localparam opcode_t OP_JNN  = 5'h07;
	localparam opcode_t OP_NOT  = 5'h08;
	localparam opcode_t OP_MOV  = 5'h10;
	localparam opcode_t OP_ADD  = 5'h11;
	localparam opcode_t OP_SUB  = 5'h12;
	localparam opcode_t OP_MUL  = 5'h13;
	localparam opcode_t OP_DIV  = 5'h14;
	localparam opcode_t OP_CMP  = 5'h15;
	localparam opcode_t OP_SHL  = 5'h16;
	localparam opcode_t OP_SHR  = 5'h17;
	localparam opcode_t OP_SAR  = 5'h18;
	localparam opcode_t OP_AND  = 5'h19;
	localparam opcode_t OP_OR   = 5'h1A;
	localparam opcode_t OP_XOR  = 5'h1B;
	localparam opcode_t OP_SWAP = 5'h1C;
	localparam opcode_t OP_LDL  = 5'h1D;
	localparam opcode_t OP_LDH  = 5'h1E;

	localparam word_t SignMask = 32'h8000_0000;
	localparam word_t HighMask = 32'hFFFF_0000;
	localparam word_t LowMask  = 32'h0000_FFFF;

	// controller to datapath
	typedef struct packed {
		logic load;     // capture operands, compute non-div ops
		logic div_step; // one quotient bit
		logic finish;   // build result beat, update flags
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_div;
		logic div_last;
	} dp_status_t;

endpackage

>>> rtl/core/vmalu_datapath.sv
module vmalu_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  vmalu_pkg::dp_cmd_t    cmd,
	output vmalu_pkg::dp_status_t status,
	input  logic [4:0]            opcode,
	input  logic signed [31:0]    op_a,
	input  logic signed [31:0]    op_b,
	output logic signed [31:0]    result_a,
	output logic                  write_a,
	output logic signed [31:0]    result_b,
	output logic                  write_b,
	output logic signed [31:0]    remainder,
	output logic                  write_remainder,
	output logic                  branch_taken,
	output logic [1:0]            flags_out,
	output logic                  bad_opcode,
	output logic                  divide_by_zero
);
	import vmalu_pkg::*;

	logic    neg_q, zero_q;
	opcode_t op_q;
	word_t   a_q, b_q, ra_q, rb_q;
	logic    wa_q, wb_q, br_q, bad_q, fl_q, cmp_q;
	word_t   quo_q, rem_q, div_q;
	logic [CntWidth-1:0] cnt_q;
	logic    na_q, nb_q, dz_q, ovf_q;

	word_t ra_c, rb_c, sar_c, cmpv;
	logic  wa_c, wb_c, br_c, bad_c, fl_c;
	logic [DataWidth:0] trial;
	word_t rem_sh;
	logic  big;

	assign big = |op_b[31:5];
	assign sar_c = big ? {DataWidth{op_a[31]}} : word_t'(op_a >>> op_b[4:0]);

	// combinational results of the non-div operations
	always_comb begin
		ra_c = '0; rb_c = '0; wa_c = 1'b0; wb_c = 1'b0; br_c = 1'b0;
		bad_c = 1'b0; fl_c = 1'b1;
		case (opcode)
			OP_JMP: begin br_c = 1'b1; fl_c = 1'b0; end
			OP_JZ:  begin br_c = zero_q; fl_c = 1'b0; end
			OP_JP:  begin br_c = !neg_q && !zero_q; fl_c = 1'b0; end
			OP_JN:  begin br_c = neg_q; fl_c = 1'b0; end
			OP_JNZ: begin br_c = !zero_q; fl_c = 1'b0; end
			OP_JNP: begin br_c = neg_q || zero_q; fl_c = 1'b0; end
			OP_JNN: begin br_c = !neg_q; fl_c = 1'b0; end
			OP_NOT: begin ra_c = ~op_a; wa_c = 1'b1; end
			OP_MOV: begin ra_c = op_b; wa_c = 1'b1; fl_c = 1'b0; end
			OP_ADD: begin ra_c = op_a + op_b; wa_c = 1'b1; end
			OP_SUB: begin ra_c = op_a - op_b; wa_c = 1'b1; end
			OP_MUL: begin ra_c = word_t'(op_a * op_b); wa_c = 1'b1; end
			OP_DIV: begin wa_c = 1'b1; end
			OP_CMP: begin fl_c = 1'b0; end
			OP_SHL: begin ra_c = big ? '0 : op_a << op_b[4:0]; wa_c = 1'b1; end
			OP_SHR: begin ra_c = big ? '0 : word_t'(op_a) >> op_b[4:0]; wa_c = 1'b1; end
			OP_SAR: begin ra_c = sar_c; wa_c = 1'b1; end
			OP_AND: begin ra_c = op_a & op_b; wa_c = 1'b1; end
			OP_OR:  begin ra_c = op_a | op_b; wa_c = 1'b1; end
			OP_XOR: begin ra_c = op_a ^ op_b; wa_c = 1'b1; end
			OP_SWAP: begin ra_c = op_b; rb_c = op_a; wa_c = 1'b1; wb_c = 1'b1; end
			OP_LDL: begin ra_c = (op_a & HighMask) | (op_b & LowMask); wa_c = 1'b1; end
			OP_LDH: begin ra_c = (op_a & LowMask) | {op_b[15:0], 16'h0000}; wa_c = 1'b1; end
			default: begin bad_c = 1'b1; fl_c = 1'b0; end
		endcase
	end

	assign cmpv = a_q - b_q;

	// restoring divider, one bit per cycle
	assign rem_sh = {rem_q[DataWidth-2:0], quo_q[DataWidth-1]};
	assign trial  = {1'b0, rem_sh} - {1'b0, div_q};

	assign status.is_div   = (opcode == OP_DIV);
	assign status.div_last = (cnt_q == CntWidth'(DataWidth - 1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= opcode; a_q <= op_a; b_q <= op_b;
			ra_q <= ra_c; rb_q <= rb_c; wa_q <= wa_c; wb_q <= wb_c;
			br_q <= br_c; bad_q <= bad_c; fl_q <= fl_c;
			cmp_q <= (opcode == OP_CMP);
			na_q <= op_a[31]; nb_q <= op_b[31];
			quo_q <= op_a[31] ? -op_a : op_a;
			div_q <= op_b[31] ? -op_b : op_b;
			rem_q <= '0;
			cnt_q <= '0;
			dz_q  <= (op_b == '0);
			ovf_q <= (op_a == SignMask) && (op_b == '1);
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + CntWidth'(1);
			if (!trial[DataWidth]) begin
				rem_q <= trial[DataWidth-1:0];
				quo_q <= {quo_q[DataWidth-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[DataWidth-2:0], 1'b0};
			end
		end
	end

	// result beat and flags
	word_t fin_a, fin_r;
	always_comb begin
		fin_a = ra_q; fin_r = '0;
		if (op_q == OP_DIV) begin
			if (dz_q) begin fin_a = '0; fin_r = '0; end
			else if (ovf_q) begin fin_a = SignMask; fin_r = '0; end
			else begin
				fin_a = (na_q != nb_q) ? -quo_q : quo_q;
				fin_r = na_q ? -rem_q : rem_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q <= 1'b0; zero_q <= 1'b0;
		end else if (cmd.finish) begin
			if (fl_q) begin
				neg_q <= fin_a[31]; zero_q <= (fin_a == '0);
			end else if (cmp_q) begin
				neg_q <= cmpv[31]; zero_q <= (cmpv == '0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result_a <= fin_a; write_a <= wa_q;
			result_b <= rb_q;  write_b <= wb_q;
			remainder <= fin_r; write_remainder <= (op_q == OP_DIV);
			branch_taken <= br_q; bad_opcode <= bad_q;
			divide_by_zero <= (op_q == OP_DIV) && dz_q;
		end
	end

	assign flags_out = {neg_q, zero_q};
endmodule

>>> rtl/core/vmalu_ctrl.sv
module vmalu_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  logic                  out_stall,
	input  vmalu_pkg::dp_status_t status,
	output vmalu_pkg::dp_cmd_t    cmd
);
	import vmalu_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_FIN  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) state_d = status.is_div ? ST_DIV : ST_FIN;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end
endmodule

>>> rtl/core/vm_alu_with_condition_codes_top.sv
// execute stage of a small 32-bit vm with n and z condition flags
// input channel: in_valid/in_stall with opcode, op_a, op_b
// output channel: out_valid/out_stall with one result beat per input beat
// a beat is taken at a clock edge where valid is high and stall is low
// one item is in flight at a time; in_stall is high until its result beat leaves
// non-div ops: accept (load), then finish registers the result beat, then out shows it
// div: accept, then the restoring divider steps (one quotient bit each step),
// then finish and out as for others; out waits while the receiver stalls
// the divider's bit loop makes a div item take longer than the others
// reset (arst_n low) clears the flags and returns the controller to idle
// when the receiver stalls, the result beat holds and no new beat is taken
// flags_out shows the flags after the step of the beat on the output
module vm_alu_with_condition_codes_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [4:0]         opcode,
	input  logic signed [31:0] op_a,
	input  logic signed [31:0] op_b,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] result_a,
	output logic               write_a,
	output logic signed [31:0] result_b,
	output logic               write_b,
	output logic signed [31:0] remainder,
	output logic               write_remainder,
	output logic               branch_taken,
	output logic [1:0]         flags_out,
	output logic               bad_opcode,
	output logic               divide_by_zero
);
	import vmalu_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// sequencer
	vmalu_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
		.status, .cmd
	);

	// operation units and flags
	vmalu_datapath u_dp (
		.clk, .arst_n, .cmd, .status, .opcode, .op_a, .op_b,
		.result_a, .write_a, .result_b, .write_b, .remainder,
		.write_remainder, .branch_taken, .flags_out, .bad_opcode,
		.divide_by_zero
	);
endmodule

>>> rtl/core/vmalu_checker.sv
module vmalu_checker (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic write_b,
	input logic write_a,
	input logic write_remainder,
	input logic divide_by_zero,
	input logic bad_opcode,
	input logic branch_taken
);
	// one item in flight: no input taken while a result waits
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken with result pending");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped");

	// swap writes a too
	a_swap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_b |-> write_a) else $error("write_b without write_a");

	// divide by zero only with div
	a_dz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_by_zero |-> write_remainder) else $error("dz without div");

	// bad opcode does not write a and takes no branch
	a_bad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_opcode |-> !write_a && !branch_taken)
		else $error("bad opcode with effects");
endmodule

bind vm_alu_with_condition_codes_top vmalu_checker u_chk (
	.clk, .arst_n, .in_stall, .out_valid, .out_stall,
	.write_b, .write_a, .write_remainder, .divide_by_zero, .bad_opcode,
	.branch_taken
);

>>> sim/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import vmalu_pkg::*;

	localparam int NumRandom = 950;
	localparam int CycleLimit = 400000;

	// one result beat
	typedef struct packed {
		word_t      res_a;
		logic       wr_a;
		word_t      res_b;
		logic       wr_b;
		word_t      rem;
		logic       wr_rem;
		logic       taken;
		logic [1:0] flags;
		logic       bad;
		logic       dz;
	} exec_result_t;

	// directed stimulus row
	typedef struct {
		opcode_t      op;
		word_t        a;
		word_t        b;
		logic         has_exp;
		exec_result_t exp;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [4:0] opcode = '0;
	logic signed [31:0] op_a = '0;
	logic signed [31:0] op_b = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] result_a, result_b, remainder;
	logic write_a, write_b, write_remainder, branch_taken, bad_opcode, divide_by_zero;
	logic [1:0] flags_out;

	exec_result_t result_q[$];
	logic         known_q[$];
	exec_result_t known_val_q[$];
	logic pred_n = 1'b0, pred_z = 1'b0;
	int errors = 0;
	int cycles = 0;
	bit long_hold = 1'b0;
	bit stim_done = 1'b0;

	vm_alu_with_condition_codes_top u_dut (.*);

	always #6 clk = ~clk;

	// flag-tracking predictor of one execute step
	function automatic exec_result_t execute(opcode_t op, word_t a, word_t b);
		exec_result_t r;
		logic upd;
		word_t ma, mb, q, rm;
		r = '0;
		upd = 1'b1;
		case (op)
			OP_JMP: begin r.taken = 1'b1; upd = 1'b0; end
			OP_JZ: begin r.taken = pred_z; upd = 1'b0; end
			OP_JP: begin r.taken = !pred_n && !pred_z; upd = 1'b0; end
			OP_JN: begin r.taken = pred_n; upd = 1'b0; end
			OP_JNZ: begin r.taken = !pred_z; upd = 1'b0; end
			OP_JNP: begin r.taken = pred_n || pred_z; upd = 1'b0; end
			OP_JNN: begin r.taken = !pred_n; upd = 1'b0; end
			OP_NOT: begin r.res_a = ~a; r.wr_a = 1'b1; end
			OP_MOV: begin r.res_a = b; r.wr_a = 1'b1; upd = 1'b0; end
			OP_ADD: begin r.res_a = a + b; r.wr_a = 1'b1; end
			OP_SUB: begin r.res_a = a - b; r.wr_a = 1'b1; end
			OP_MUL: begin r.res_a = a * b; r.wr_a = 1'b1; end
			OP_DIV: begin
				r.wr_a = 1'b1;
				r.wr_rem = 1'b1;
				if (b == '0) begin
					r.dz = 1'b1;
				end else if (a == SignMask && b == '1) begin
					r.res_a = SignMask;
				end else begin
					ma = a[31] ? -a : a;
					mb = b[31] ? -b : b;
					q = ma / mb;
					rm = ma % mb;
					r.res_a = (a[31] != b[31]) ? -q : q;
					r.rem = a[31] ? -rm : rm;
				end
			end
			OP_CMP: begin
				q = a - b;
				pred_n = q[31];
				pred_z = (q == '0);
				upd = 1'b0;
			end
			OP_SHL: begin r.res_a = (b >= 32) ? '0 : a << b[4:0]; r.wr_a = 1'b1; end
			OP_SHR: begin r.res_a = (b >= 32) ? '0 : a >> b[4:0]; r.wr_a = 1'b1; end
			OP_SAR: begin
				r.res_a = (b >= 32) ? {32{a[31]}} : word_t'($signed(a) >>> b[4:0]);
				r.wr_a = 1'b1;
			end
			OP_AND: begin r.res_a = a & b; r.wr_a = 1'b1; end
			OP_OR: begin r.res_a = a | b; r.wr_a = 1'b1; end
			OP_XOR: begin r.res_a = a ^ b; r.wr_a = 1'b1; end
			OP_SWAP: begin
				r.res_a = b; r.res_b = a; r.wr_a = 1'b1; r.wr_b = 1'b1;
			end
			OP_LDL: begin r.res_a = (a & HighMask) | (b & LowMask); r.wr_a = 1'b1; end
			OP_LDH: begin r.res_a = (a & LowMask) | ((b & LowMask) << 16); r.wr_a = 1'b1; end
			default: begin r.bad = 1'b1; upd = 1'b0; end
		endcase
		if (upd) begin
			pred_n = r.res_a[31];
			pred_z = (r.res_a == '0);
		end
		r.flags = {pred_n, pred_z};
		return r;
	endfunction

	// offer one beat and wait for acceptance
	task automatic send_beat(opcode_t op, word_t a, word_t b);
		opcode <= op;
		op_a <= a;
		op_b <= b;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		result_q.push_back(execute(op, a, b));
		@(negedge clk);
	endtask

	task automatic idle_gap(int n);
		in_valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	function automatic word_t rand_word();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return SignMask;
			3: return 32'h7FFF_FFFF;
			4: return $urandom_range(0, 40);
			default: return $urandom;
		endcase
	endfunction

	function automatic opcode_t rand_op();
		if ($urandom_range(0, 15) == 0) return opcode_t'($urandom_range(0, 31));
		if ($urandom_range(0, 3) == 0) return opcode_t'($urandom_range(1, 8));
		return opcode_t'($urandom_range(16, 30));
	endfunction

	// sender: directed table then random bursts
	initial begin
		stim_row_t rows[$];
		stim_row_t row;
		exec_result_t e;
		int burst;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// jz right after reset sees cleared flags
		e = '0;
		row = '{OP_JZ, 32'h1234, 0, 1'b1, e}; rows.push_back(row);
		e = '0; e.taken = 1'b1;
		row = '{OP_JMP, 32'h10, 0, 1'b1, e}; rows.push_back(row);
		// divide by zero
		e = '0; e.wr_a = 1'b1; e.wr_rem = 1'b1; e.dz = 1'b1; e.flags = 2'b01;
		row = '{OP_DIV, 32'd77, 0, 1'b1, e}; rows.push_back(row);
		// most negative over minus one
		e = '0; e.wr_a = 1'b1; e.wr_rem = 1'b1; e.res_a = SignMask; e.flags = 2'b10;
		row = '{OP_DIV, SignMask, '1, 1'b1, e}; rows.push_back(row);
		// invalid opcode keeps flags
		e = '0; e.bad = 1'b1; e.flags = 2'b10;
		row = '{5'h1F, '1, '1, 1'b1, e}; rows.push_back(row);
		e = '0; e.bad = 1'b1; e.flags = 2'b10;
		row = '{5'h00, 0, 0, 1'b1, e}; rows.push_back(row);
		e = '0; e.bad = 1'b1; e.flags = 2'b10;
		row = '{5'h09, 0, 0, 1'b1, e}; rows.push_back(row);
		e = '0;
		row = '{OP_ADD, 32'h7FFF_FFFF, 1, 1'b0, e}; rows.push_back(row);
		row = '{OP_SUB, SignMask, 1, 1'b0, e}; rows.push_back(row);
		row = '{OP_MUL, '1, '1, 1'b0, e}; rows.push_back(row);
		row = '{OP_DIV, -7, 2, 1'b0, e}; rows.push_back(row);
		row = '{OP_CMP, 5, 5, 1'b0, e}; rows.push_back(row);
		row = '{OP_JNP, 0, 0, 1'b0, e}; rows.push_back(row);
		row = '{OP_SHL, 1, 31, 1'b0, e}; rows.push_back(row);
		row = '{OP_SHL, 1, 32, 1'b0, e}; rows.push_back(row);
		row = '{OP_SHR, '1, SignMask, 1'b0, e}; rows.push_back(row);
		row = '{OP_SAR, SignMask, 32'd40, 1'b0, e}; rows.push_back(row);
		row = '{OP_SAR, SignMask, 0, 1'b0, e}; rows.push_back(row);
		row = '{OP_AND, '1, 32'h0F0F_0F0F, 1'b0, e}; rows.push_back(row);
		row = '{OP_OR, 0, 0, 1'b0, e}; rows.push_back(row);
		row = '{OP_XOR, '1, 0, 1'b0, e}; rows.push_back(row);
		row = '{OP_NOT, 0, 0, 1'b0, e}; rows.push_back(row);
		row = '{OP_SWAP, 32'hDEAD_BEEF, 32'h0000_0001, 1'b0, e}; rows.push_back(row);
		row = '{OP_LDL, 32'hAAAA_AAAA, 32'h1234_5555, 1'b0, e}; rows.push_back(row);
		row = '{OP_LDH, 32'hAAAA_AAAA, 32'h1234_8555, 1'b0, e}; rows.push_back(row);
		row = '{OP_MOV, 0, '1, 1'b0, e}; rows.push_back(row);
		row = '{OP_JP, 0, 0, 1'b0, e}; rows.push_back(row);
		row = '{OP_JN, 0, 0, 1'b0, e}; rows.push_back(row);
		row = '{OP_JNZ, 0, 0, 1'b0, e}; rows.push_back(row);
		row = '{OP_JNN, 0, 0, 1'b0, e}; rows.push_back(row);
		foreach (rows[i]) begin
			known_q.push_back(rows[i].has_exp);
			known_val_q.push_back(rows[i].exp);
			send_beat(rows[i].op, rows[i].a, rows[i].b);
		end
		// wait until the block drains completely
		in_valid <= 1'b0;
		while (result_q.size() != 0) @(negedge clk);
		// long receiver hold-off while items keep coming
		long_hold = 1'b1;
		for (int i = 0; i < NumRandom; i++) begin
			if (i == 40) long_hold = 1'b0;
			known_q.push_back(1'b0);
			known_val_q.push_back('0);
			send_beat(rand_op(), rand_word(), rand_word());
			if (burst > 0) begin
				burst--;
			end else begin
				burst = $urandom_range(0, 12);
				if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 6));
			end
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// receiver stall pattern
	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				hold = 0;
				while (hold < 300) begin
					@(negedge clk);
					hold++;
				end
				out_stall <= 1'b0;
				while (long_hold) @(negedge clk);
			end else if ($urandom_range(0, 63) < 8) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(10, 40)) @(negedge clk);
			end else begin
				out_stall <= ($urandom_range(0, 3) == 0);
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		exec_result_t got, want;
		logic known;
		exec_result_t kval;
		if (arst_n && out_valid && !out_stall) begin
			got = '{result_a, write_a, result_b, write_b, remainder, write_remainder,
				branch_taken, flags_out, bad_opcode, divide_by_zero};
			if (result_q.size() == 0) begin
				$display("%0t: unexpected result beat %h", $realtime, got);
				errors++;
			end else begin
				want = result_q.pop_front();
				known = known_q.pop_front();
				kval = known_val_q.pop_front();
				if (known && kval != want) begin
					$display("%0t: table row exp %h pred %h", $realtime, kval, want);
					errors++;
				end
				if (known) want = kval;
				if (got != want) begin
					$display("%0t: mismatch exp %h act %h", $realtime, want, got);
					errors++;
				end
			end
		end
	end

	// end of run and timeout
	initial begin
		while (!(stim_done && result_q.size() == 0) && cycles < CycleLimit) @(posedge clk);
		repeat (50) @(posedge clk);
		if (cycles >= CycleLimit) begin
			$display("** vm_alu_with_condition_codes_top: FAILED **");
		end else if (errors == 0) begin
			$display("** vm_alu_with_condition_codes_top: PASSED **");
		end else begin
			$display("** vm_alu_with_condition_codes_top: FAILED **");
		end
		$finish;
	end

	always @(posedge clk) cycles <= cycles + 1;

endmodule
